// File: rtl/tsq_pkg.sv
// tsq_pkg: shared types and constants for the two-stack queue
// used by tsq_ctrl, tsq_dp and two_stack_queue; no dependencies
`default_nettype none

package tsq_pkg;

  // default stack depth
  localparam int unsigned DEF_STACK_DEPTH = 1024;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // request action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // value reported by a pop on an empty queue
  localparam logic signed [31:0] POP_NONE = -32'sd1;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_READ
  } state_t;

  // which result goes into the output register
  typedef enum logic [1:0] {
    RES_PUSH_OK,
    RES_PUSH_FULL,
    RES_EMPTY,
    RES_POP
  } res_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;  // latch the accepted request
    logic     push_wr;  // write request value onto inbound stack
    logic     pop_rd;   // read and drop top of outbound stack
    logic     mv_rd;    // read and drop top of inbound stack for a transfer
    logic     load;     // load output register
    res_sel_t sel;      // result source for load
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_empty;
    logic in_full;
    logic out_empty;
    logic mv_pend;      // transfer read in flight, write follows this cycle
    logic out_free;     // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/tsq_ctrl.sv
// tsq_ctrl: sequencer for the two-stack queue
// depends on tsq_pkg; drives tsq_dp through tsq_pkg::cmd_t
`default_nettype none

module tsq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           action,
  input  wire tsq_pkg::stat_t stat,
  output tsq_pkg::cmd_t       cmd
);

  tsq_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    cmd         = '0;
    cmd.sel     = tsq_pkg::RES_PUSH_OK;
    unique case (state)
      tsq_pkg::S_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.capture = 1'b1;
          if (action == tsq_pkg::ACT_PUSH) begin
            // push completes in the accept cycle
            cmd.push_wr = !stat.in_full;
            cmd.load    = 1'b1;
            if (stat.in_full) begin
              cmd.sel = tsq_pkg::RES_PUSH_FULL;
            end else begin
              cmd.sel = tsq_pkg::RES_PUSH_OK;
            end
          end else if (!stat.out_empty) begin
            cmd.pop_rd = 1'b1;
            state_next = tsq_pkg::S_READ;
          end else if (stat.in_empty) begin
            cmd.load = 1'b1;
            cmd.sel  = tsq_pkg::RES_EMPTY;
          end else begin
            state_next = tsq_pkg::S_MOVE;
          end
        end
      end
      tsq_pkg::S_MOVE: begin
        // one element read per cycle, written to outbound in the cycle after its read
        cmd.mv_rd = !stat.in_empty;
        if (stat.in_empty && !stat.mv_pend) begin
          cmd.pop_rd = 1'b1;
          state_next = tsq_pkg::S_READ;
        end
      end
      tsq_pkg::S_READ: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = tsq_pkg::RES_POP;
          state_next = tsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tsq_dp.sv
// tsq_dp: datapath of the two-stack queue: both stack memories, counts,
// request register and output register; depends on tsq_pkg
`default_nettype none

module tsq_dp #(
  parameter int unsigned STACK_DEPTH = tsq_pkg::DEF_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] value,
  input  wire tsq_pkg::cmd_t      cmd,
  output tsq_pkg::stat_t          stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      popped,
  output logic                    matched,
  output logic [1:0]              status
);

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

  logic [31:0]        in_mem  [STACK_DEPTH];
  logic [31:0]        out_mem [STACK_DEPTH];
  logic [CNT_W-1:0]   in_count;
  logic [CNT_W-1:0]   out_count;
  logic [CNT_W-1:0]   in_top;
  logic [CNT_W-1:0]   out_top;
  logic [31:0]        in_rdata;
  logic [31:0]        out_rdata;
  logic               mv_pend;
  logic signed [31:0] expect_val;

  assign in_top  = in_count - CNT_W'(1);
  assign out_top = out_count - CNT_W'(1);

  // status to controller
  assign stat.in_empty  = (in_count == '0);
  assign stat.in_full   = (in_count == CNT_W'(STACK_DEPTH));
  assign stat.out_empty = (out_count == '0);
  assign stat.mv_pend   = mv_pend;
  assign stat.out_free  = !out_valid || !out_stall;

  // inbound stack memory
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      in_mem[in_count[ADDR_W-1:0]] <= value;
    end
    if (cmd.mv_rd) begin
      in_rdata <= in_mem[in_top[ADDR_W-1:0]];
    end
  end

  // outbound stack memory
  always_ff @(posedge clk) begin
    if (mv_pend) begin
      out_mem[out_count[ADDR_W-1:0]] <= in_rdata;
    end
    if (cmd.pop_rd) begin
      out_rdata <= out_mem[out_top[ADDR_W-1:0]];
    end
  end

  // stack counts and transfer pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
      mv_pend   <= 1'b0;
    end else begin
      mv_pend <= cmd.mv_rd;
      if (cmd.push_wr) begin
        in_count <= in_count + CNT_W'(1);
      end else if (cmd.mv_rd) begin
        in_count <= in_top;
      end
      if (mv_pend) begin
        out_count <= out_count + CNT_W'(1);
      end else if (cmd.pop_rd) begin
        out_count <= out_top;
      end
    end
  end

  // request register: expected value for a pop
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      expect_val <= value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (cmd.sel)
        tsq_pkg::RES_PUSH_OK: begin
          popped  <= '0;
          matched <= 1'b1;
          status  <= tsq_pkg::ST_OK;
        end
        tsq_pkg::RES_PUSH_FULL: begin
          popped  <= '0;
          matched <= 1'b0;
          status  <= tsq_pkg::ST_FULL;
        end
        tsq_pkg::RES_EMPTY: begin
          popped  <= tsq_pkg::POP_NONE;
          matched <= (value == tsq_pkg::POP_NONE);
          status  <= tsq_pkg::ST_EMPTY;
        end
        tsq_pkg::RES_POP: begin
          popped  <= out_rdata;
          matched <= (out_rdata == expect_val);
          status  <= tsq_pkg::ST_OK;
        end
        default: begin
          popped  <= '0;
          matched <= 1'b0;
          status  <= tsq_pkg::ST_OK;
        end
      endcase
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (in_count <= CNT_W'(STACK_DEPTH)) && (out_count <= CNT_W'(STACK_DEPTH)))
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> (out_count != '0) && !mv_pend)
    else $error("pop read on empty outbound stack or during transfer write");

  a_move_outbound: assert property (@(posedge clk) disable iff (rst)
    cmd.mv_rd |-> (in_count != '0) && !cmd.push_wr)
    else $error("transfer read on empty inbound stack");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled result");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push_wr |=> (in_count == $past(in_count) + CNT_W'(1)))
    else $error("push did not advance inbound count");

endmodule

`default_nettype wire

// File: rtl/two_stack_queue.sv
// two_stack_queue: first-in first-out queue built from two stacks
// top level; instantiates tsq_ctrl and tsq_dp, uses tsq_pkg
//
// Input channel (in_valid / in_stall, action, value): each request is a
// push of value (action 0) or a pop compared against value (action 1).
// Output channel (out_valid / out_stall, popped, matched, status): one
// result per request, in request order.
// A push writes the inbound stack and loads its result in the accept cycle.
// A pop from a non-empty outbound stack reads the memory into a register
// (S_READ), then loads the output register. A pop that finds the outbound
// stack empty first moves all n inbound elements, limited by the single read
// port of each stack memory: one element per cycle.
// A push onto a full inbound stack is dropped with status 2; a pop on an
// empty queue returns -1 with status 1.
// Reset clears both stack counts and the output valid; the memories need no
// clearing pass, so requests are taken in the cycle after reset.
// While out_stall holds a result, the block raises in_stall and waits.
`default_nettype none

module two_stack_queue #(
  parameter int unsigned STACK_DEPTH = tsq_pkg::DEF_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      popped,
  output logic                    matched,
  output logic [1:0]              status
);

  tsq_pkg::cmd_t  cmd;
  tsq_pkg::stat_t stat;

  // sequencer
  tsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stacks and result register
  tsq_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .popped    (popped),
    .matched   (matched),
    .status    (status)
  );

endmodule

`default_nettype wire
